// ===== rtl/apdc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// apdc_pkg: shared types and constants for the analog port device classifier
// Holds the sample widths, class codes, register indexes and the bundles that
// pass between the window tracker and the decision logic.
// ----------------------------------------------------------------------------
package apdc_pkg;

  // Sample and threshold widths
  localparam int MV_W           = 13;
  localparam int CNT_W          = 8;
  localparam int DEFAULT_WINDOW = 16;

  localparam logic [MV_W-1:0]  FULL_MV        = 13'd5000;
  localparam logic [CNT_W-1:0] SERIAL_REPEATS = 8'd2;
  localparam logic [CNT_W-1:0] STREAK_MAX     = 8'd255;

  // Register reset values
  localparam logic [MV_W-1:0]  RST_UART_SWING = 13'd2500;
  localparam logic [MV_W-1:0]  RST_HIGH_LEVEL = 13'd3000;
  localparam logic [MV_W-1:0]  RST_LOW_LEVEL  = 13'd1000;
  localparam logic [MV_W-1:0]  RST_FLAT_SWING = 13'd500;
  localparam logic [MV_W-1:0]  RST_CH1_LOW    = 13'd500;
  localparam logic [MV_W-1:0]  RST_CH1_HIGH   = 13'd2500;
  localparam logic [CNT_W-1:0] RST_CONFIRM    = 8'd5;

  // Window class codes
  typedef enum logic [2:0] {
    CLS_NONE   = 3'd0,
    CLS_SERIAL = 3'd1,
    CLS_TRAIN  = 3'd2,
    CLS_SIMPLE = 3'd3,
    CLS_LIGHT  = 3'd4
  } cls_t;

  // Held device type codes
  typedef enum logic [1:0] {
    DEV_UNKNOWN = 2'd0,
    DEV_TRAIN   = 2'd1,
    DEV_SIMPLE  = 2'd2,
    DEV_LIGHT   = 2'd3
  } dev_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_UART_SWING = 3'd0,
    REG_HIGH_LEVEL = 3'd1,
    REG_LOW_LEVEL  = 3'd2,
    REG_FLAT_SWING = 3'd3,
    REG_CH1_LOW    = 3'd4,
    REG_CH1_HIGH   = 3'd5,
    REG_CONFIRM    = 3'd6
  } reg_idx_t;

  // Threshold set
  typedef struct packed {
    logic [MV_W-1:0]  uart_swing;
    logic [MV_W-1:0]  high_level;
    logic [MV_W-1:0]  low_level;
    logic [MV_W-1:0]  flat_swing;
    logic [MV_W-1:0]  ch1_low;
    logic [MV_W-1:0]  ch1_high;
    logic [CNT_W-1:0] confirm;
  } cfg_t;

  // Extremes of one finished window
  typedef struct packed {
    logic [MV_W-1:0] ch0_lo;
    logic [MV_W-1:0] ch0_hi;
    logic [MV_W-1:0] ch1_lo;
    logic [MV_W-1:0] ch1_hi;
  } win_t;

  // One result transaction
  typedef struct packed {
    cls_t             window_class;
    logic [CNT_W-1:0] streak;
    dev_t             device_type;
    logic             dumb_device;
    logic             uart_request;
  } result_t;

  // Clamp a sample to full scale
  function automatic logic [MV_W-1:0] sat_mv(input logic [MV_W-1:0] v);
    sat_mv = (v > FULL_MV) ? FULL_MV : v;
  endfunction

  // Max minus min, zero if the pair is inverted
  function automatic logic [MV_W-1:0] swing(input logic [MV_W-1:0] hi,
                                            input logic [MV_W-1:0] lo);
    swing = (hi >= lo) ? (hi - lo) : '0;
  endfunction

endpackage : apdc_pkg
`default_nettype wire

// ===== rtl/analog_port_device_classifier_top.sv =====
`default_nettype none
// Result path: a window's result is offered on out_* once its last sample pair
//   is accepted; the window register loads when that pair is accepted, and the
//   result register loads from it once the output is free to take it.
// Throughput: one sample pair per cycle, sustained; in_ready falls only while
//   a finished window and a result both wait on a stalled output.
// Reset: synchronous, active low; thresholds return to defaults, the window,
//   streak, held type and passive flag are cleared.
// ----------------------------------------------------------------------------
// analog_port_device_classifier_top: port voltage device classifier
// Tracks per-channel extremes over WINDOW sample pairs and, at each window's
// end, classifies the port and confirms the device over repeated windows.
// ----------------------------------------------------------------------------
module analog_port_device_classifier_top import apdc_pkg::*; #(
  parameter int WINDOW = DEFAULT_WINDOW
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // sample pair channel
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [MV_W-1:0]  in_ch0_mv,
  input  wire logic [MV_W-1:0]  in_ch1_mv,
  // result channel
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [2:0]            out_window_class,
  output logic [CNT_W-1:0]      out_streak,
  output logic [1:0]            out_device_type,
  output logic                  out_dumb_device,
  output logic                  out_uart_request,
  // configuration write channel
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [MV_W-1:0]  cfg_data
);

  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW - 1);

  cfg_t             cfg_r;
  logic [IDX_W-1:0] idx_r;
  win_t             run_r, run_nxt;
  win_t             win_r;
  logic             win_valid_r;
  logic             in_fire, judge_fire, idx_last;
  logic [MV_W-1:0]  a, b;
  result_t          res, out_r;
  logic             out_valid_r;

  // Handshakes
  assign cfg_ready  = 1'b1;
  assign judge_fire = win_valid_r && (!out_valid_r || out_ready);
  assign in_ready   = !win_valid_r || judge_fire;
  assign in_fire    = in_valid && in_ready;
  assign idx_last   = (idx_r == IDX_LAST);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.uart_swing <= RST_UART_SWING;
      cfg_r.high_level <= RST_HIGH_LEVEL;
      cfg_r.low_level  <= RST_LOW_LEVEL;
      cfg_r.flat_swing <= RST_FLAT_SWING;
      cfg_r.ch1_low    <= RST_CH1_LOW;
      cfg_r.ch1_high   <= RST_CH1_HIGH;
      cfg_r.confirm    <= RST_CONFIRM;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_UART_SWING: cfg_r.uart_swing <= cfg_data;
        REG_HIGH_LEVEL: cfg_r.high_level <= cfg_data;
        REG_LOW_LEVEL:  cfg_r.low_level  <= cfg_data;
        REG_FLAT_SWING: cfg_r.flat_swing <= cfg_data;
        REG_CH1_LOW:    cfg_r.ch1_low    <= cfg_data;
        REG_CH1_HIGH:   cfg_r.ch1_high   <= cfg_data;
        REG_CONFIRM:    cfg_r.confirm    <= cfg_data[CNT_W-1:0];
        default:        ;
      endcase
    end
  end

  // Running extremes with the incoming pair folded in
  always_comb begin
    a       = sat_mv(in_ch0_mv);
    b       = sat_mv(in_ch1_mv);
    run_nxt = run_r;
    if (a < run_r.ch0_lo) run_nxt.ch0_lo = a;
    if (a > run_r.ch0_hi) run_nxt.ch0_hi = a;
    if (b < run_r.ch1_lo) run_nxt.ch1_lo = b;
    if (b > run_r.ch1_hi) run_nxt.ch1_hi = b;
  end

  // Window tracker
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      run_r  <= '{ch0_lo: FULL_MV, ch0_hi: '0, ch1_lo: FULL_MV, ch1_hi: '0};
    end else if (in_fire) begin
      if (idx_last) begin
        idx_r <= '0;
        run_r <= '{ch0_lo: FULL_MV, ch0_hi: '0, ch1_lo: FULL_MV, ch1_hi: '0};
      end else begin
        idx_r <= idx_r + IDX_W'(1);
        run_r <= run_nxt;
      end
    end
  end

  // Finished window register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_valid_r <= 1'b0;
    end else if (in_fire && idx_last) begin
      win_valid_r <= 1'b1;
    end else if (judge_fire) begin
      win_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && idx_last) win_r <= run_nxt;
  end

  // Classification and confirmation
  apdc_judge u_judge (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (judge_fire),
    .win   (win_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (judge_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (judge_fire) out_r <= res;
  end

  assign out_valid        = out_valid_r;
  assign out_window_class = out_r.window_class;
  assign out_streak       = out_r.streak;
  assign out_device_type  = out_r.device_type;
  assign out_dumb_device  = out_r.dumb_device;
  assign out_uart_request = out_r.uart_request;

`ifndef SYNTH
  // Last pair of a window always leaves a finished window pending
  a_win_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && idx_last |=> win_valid_r)
    else $error("finished window not captured");

  // Input stalls only when both window and result stages are full
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> win_valid_r && out_valid_r && !out_ready)
    else $error("input stalled without backpressure");

  // A serial request only comes with a serial window
  a_uart_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_uart_request |-> out_window_class == CLS_SERIAL)
    else $error("serial request on non-serial window");

  // A none window reports a cleared streak and unknown type
  a_none_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_window_class == CLS_NONE |->
      out_streak == '0 && out_device_type == DEV_UNKNOWN)
    else $error("none window result not cleared");
`endif

endmodule : analog_port_device_classifier_top
`default_nettype wire

// ===== rtl/apdc_judge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// apdc_judge: window classification and device confirmation
// Classifies one finished window from its swings and levels, and keeps the
// streak, last class, held type and passive flag across windows.
// ----------------------------------------------------------------------------
module apdc_judge import apdc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic fire,
  input  wire win_t win,
  input  wire cfg_t cfg,
  output result_t   res
);

  cls_t             last_class_r, last_class_nxt;
  logic [CNT_W-1:0] streak_r, streak_nxt;
  dev_t             held_r, held_nxt;
  logic             dumb_r, dumb_nxt;

  logic [MV_W-1:0]  d0, d1;
  logic             ch0_flat, ch1_flat;
  cls_t             cls;
  logic             uart;

  // Classification, in priority order
  always_comb begin
    d0       = swing(win.ch0_hi, win.ch0_lo);
    d1       = swing(win.ch1_hi, win.ch1_lo);
    ch0_flat = (d0 < cfg.flat_swing);
    ch1_flat = (d1 < cfg.flat_swing);
    cls      = CLS_NONE;
    priority if (d1 >= cfg.uart_swing) begin
      cls = CLS_SERIAL;
    end else if (win.ch0_hi >= cfg.high_level && ch0_flat) begin
      if (win.ch1_lo <= cfg.ch1_low && ch1_flat) cls = CLS_TRAIN;
    end else if (win.ch0_lo <= cfg.low_level && ch0_flat) begin
      priority if (win.ch1_lo <= cfg.ch1_low && ch1_flat) begin
        cls = CLS_SIMPLE;
      end else if (win.ch1_lo >= cfg.ch1_high && ch1_flat) begin
        cls = CLS_LIGHT;
      end else begin
        cls = CLS_NONE;
      end
    end else begin
      cls = CLS_NONE;
    end
  end

  // Streak and confirmation
  always_comb begin
    last_class_nxt = last_class_r;
    streak_nxt     = streak_r;
    held_nxt       = held_r;
    dumb_nxt       = dumb_r;
    uart           = 1'b0;
    if (cls == CLS_NONE) begin
      streak_nxt     = '0;
      held_nxt       = DEV_UNKNOWN;
      last_class_nxt = CLS_NONE;
    end else begin
      if (cls == last_class_r) begin
        if (streak_r != STREAK_MAX) streak_nxt = streak_r + 8'd1;
      end else begin
        last_class_nxt = cls;
        streak_nxt     = '0;
      end
      if (cls == CLS_SERIAL) begin
        if (streak_nxt >= SERIAL_REPEATS) begin
          dumb_nxt = 1'b0;
          uart     = 1'b1;
        end
      end else if (streak_nxt >= cfg.confirm) begin
        // passive class codes sit one above their device type codes
        held_nxt = dev_t'(2'(cls - CLS_SERIAL));
        dumb_nxt = 1'b1;
      end
    end
    res.window_class = cls;
    res.streak       = streak_nxt;
    res.device_type  = held_nxt;
    res.dumb_device  = dumb_nxt;
    res.uart_request = uart;
  end

  // Decision state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_class_r <= CLS_NONE;
      streak_r     <= '0;
      held_r       <= DEV_UNKNOWN;
      dumb_r       <= 1'b0;
    end else if (fire) begin
      last_class_r <= last_class_nxt;
      streak_r     <= streak_nxt;
      held_r       <= held_nxt;
      dumb_r       <= dumb_nxt;
    end
  end

`ifndef SYNTH
  // A class other than none always leaves it as the last class
  a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
    fire && cls != CLS_NONE |=> last_class_r == $past(cls))
    else $error("last class not updated");

  // A none window clears streak and held type
  a_none_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && cls == CLS_NONE |=> streak_r == '0 && held_r == DEV_UNKNOWN)
    else $error("none window did not clear");

  // Serial requests only after enough agreeing windows
  a_uart_streak: assert property (@(posedge clk) disable iff (!rst_n)
    uart |-> cls == CLS_SERIAL && streak_nxt >= SERIAL_REPEATS)
    else $error("serial request without streak");
`endif

endmodule : apdc_judge
`default_nettype wire

// ===== sim/tb_analog_port_device_classifier_top.sv =====
// ----------------------------------------------------------------------------
// tb_analog_port_device_classifier_top: self-checking bench for the classifier
// Sends sample pairs window by window and predicts each window's result with
// a local model of the extremes tracking, classification and streak logic.
// The run opens with a table of hand-picked windows. Random phases follow,
// each with its own threshold set. The sender works in bursts and the
// receiver stalls. A long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb_analog_port_device_classifier_top;
  import apdc_pkg::*;

  localparam int WIN_LEN  = 16;
  localparam int MV_TOP   = 5000;
  localparam int RAW_TOP  = 8191;

  // Spare register index: not decoded, a write must change nothing
  localparam logic [2:0] REG_SPARE = 3'd7;

  // Window content kinds for the generator
  localparam int KIND_SERIAL = 0;
  localparam int KIND_TRAIN  = 1;
  localparam int KIND_SIMPLE = 2;
  localparam int KIND_LIGHT  = 3;
  localparam int KIND_LEVEL  = 4;
  localparam int KIND_NOISE  = 5;
  localparam int KIND_ANY    = -1;

  // Threshold set styles
  localparam int TH_SANE    = 0;
  localparam int TH_ZERO    = 1;
  localparam int TH_TOP     = 2;
  localparam int TH_OVERLAP = 3;
  localparam int TH_WIDE    = 4;
  localparam int TH_SAT     = 5;

  localparam int NUM_PHASES     = 12;
  localparam int PRESSURE_PHASE = 5;

  localparam result_t NO_WANT = '{CLS_NONE, 8'd0, DEV_UNKNOWN, 1'b0, 1'b0};

  typedef struct {
    logic [MV_W-1:0] ch0;
    logic [MV_W-1:0] ch1;
    bit              typed;
    result_t         want;
  } stim_t;

  typedef struct {
    int      c0_lo;
    int      c0_hi;
    int      c1_lo;
    int      c1_hi;
    int      confirm_set;
    bit      typed;
    result_t want;
  } dir_row_t;

  // DUT connections
  logic             clk              = 1'b0;
  logic             rst_n            = 1'b0;
  logic             in_valid         = 1'b0;
  logic             in_ready;
  logic [MV_W-1:0]  in_ch0_mv        = '0;
  logic [MV_W-1:0]  in_ch1_mv        = '0;
  logic             out_valid;
  logic             out_ready        = 1'b0;
  logic [2:0]       out_window_class;
  logic [CNT_W-1:0] out_streak;
  logic [1:0]       out_device_type;
  logic             out_dumb_device;
  logic             out_uart_request;
  logic             cfg_valid        = 1'b0;
  logic             cfg_ready;
  logic [2:0]       cfg_index        = '0;
  logic [MV_W-1:0]  cfg_data         = '0;

  // Classifier model state
  cfg_t             thr;
  logic [CNT_W-1:0] win_count;
  logic [MV_W-1:0]  c0_min, c0_max, c1_min, c1_max;
  cls_t             prev_cls;
  logic [CNT_W-1:0] run_len;
  dev_t             dev_held;
  logic             passive;

  result_t expected_q [$];
  stim_t   stim_q [$];
  result_t head_want;
  int      err_count = 0;
  bit      hold_req  = 1'b0;

  // Hand-picked windows, default thresholds unless confirm_set says otherwise
  dir_row_t dir_rows [15] = '{
    '{0,    0,    0,    0,    -1, 1'b1, '{CLS_SIMPLE, 8'd0, DEV_UNKNOWN, 1'b0, 1'b0}},
    '{0,    0,    0,    8191, -1, 1'b1, '{CLS_SERIAL, 8'd0, DEV_UNKNOWN, 1'b0, 1'b0}},
    '{0,    0,    2500, 5000, -1, 1'b0, NO_WANT},
    '{0,    0,    2500, 5000, -1, 1'b1, '{CLS_SERIAL, 8'd2, DEV_UNKNOWN, 1'b0, 1'b1}},
    '{0,    0,    1001, 3500, -1, 1'b0, NO_WANT},
    '{3000, 3499, 500,  999,  -1, 1'b0, NO_WANT},
    '{8191, 5000, 0,    0,    -1, 1'b0, NO_WANT},
    '{3000, 3500, 0,    0,    -1, 1'b0, NO_WANT},
    '{5000, 5000, 600,  600,  -1, 1'b0, NO_WANT},
    '{1000, 1499, 2500, 2999, -1, 1'b0, NO_WANT},
    '{0,    0,    8191, 8191, -1, 1'b0, NO_WANT},
    '{0,    499,  2500, 2500, 0,  1'b0, NO_WANT},
    '{0,    0,    0,    8191, -1, 1'b0, NO_WANT},
    '{1001, 1001, 0,    0,    -1, 1'b1, '{CLS_NONE, 8'd0, DEV_UNKNOWN, 1'b1, 1'b0}},
    '{0,    0,    0,    0,    -1, 1'b1, '{CLS_SIMPLE, 8'd0, DEV_SIMPLE, 1'b1, 1'b0}}
  };

  int phase_style [NUM_PHASES] = '{TH_SANE, TH_ZERO, TH_SANE, TH_TOP, TH_OVERLAP, TH_SANE,
                                   TH_WIDE, TH_SANE, TH_SANE, TH_WIDE, TH_SANE, TH_SAT};

  analog_port_device_classifier_top #(.WINDOW(WIN_LEN)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_ch0_mv        (in_ch0_mv),
    .in_ch1_mv        (in_ch1_mv),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_window_class (out_window_class),
    .out_streak       (out_streak),
    .out_device_type  (out_device_type),
    .out_dumb_device  (out_dumb_device),
    .out_uart_request (out_uart_request),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model

  function automatic void clear_extremes();
    win_count = '0;
    c0_min    = FULL_MV;
    c0_max    = '0;
    c1_min    = FULL_MV;
    c1_max    = '0;
  endfunction

  function automatic void reset_classifier();
    thr      = '{RST_UART_SWING, RST_HIGH_LEVEL, RST_LOW_LEVEL, RST_FLAT_SWING,
                 RST_CH1_LOW, RST_CH1_HIGH, RST_CONFIRM};
    prev_cls = CLS_NONE;
    run_len  = '0;
    dev_held = DEV_UNKNOWN;
    passive  = 1'b0;
    clear_extremes();
  endfunction

  // Fold one sample pair into the window; returns 1 with the result at window end
  function automatic bit advance_window(input logic [MV_W-1:0] a_raw,
                                        input logic [MV_W-1:0] b_raw,
                                        output result_t res);
    logic [MV_W-1:0] a, b, sw0, sw1;
    cls_t            c;
    logic            uart;
    a    = (a_raw > FULL_MV) ? FULL_MV : a_raw;
    b    = (b_raw > FULL_MV) ? FULL_MV : b_raw;
    c    = CLS_NONE;
    uart = 1'b0;
    res  = NO_WANT;
    if (a < c0_min) c0_min = a;
    if (a > c0_max) c0_max = a;
    if (b < c1_min) c1_min = b;
    if (b > c1_max) c1_max = b;
    if (int'(win_count) + 1 < WIN_LEN) begin
      win_count = win_count + 1'b1;
      return 1'b0;
    end

    sw0 = (c0_max >= c0_min) ? c0_max - c0_min : '0;
    sw1 = (c1_max >= c1_min) ? c1_max - c1_min : '0;

    // Serial first; a high ch0 level shuts out the low branch entirely
    if (sw1 >= thr.uart_swing) begin
      c = CLS_SERIAL;
    end else if (c0_max >= thr.high_level && sw0 < thr.flat_swing) begin
      if (c1_min <= thr.ch1_low && sw1 < thr.flat_swing) c = CLS_TRAIN;
    end else if (c0_min <= thr.low_level && sw0 < thr.flat_swing) begin
      if (c1_min <= thr.ch1_low && sw1 < thr.flat_swing) c = CLS_SIMPLE;
      else if (c1_min >= thr.ch1_high && sw1 < thr.flat_swing) c = CLS_LIGHT;
    end

    // Streak and confirmation
    if (c == CLS_NONE) begin
      run_len  = '0;
      dev_held = DEV_UNKNOWN;
      prev_cls = CLS_NONE;
    end else begin
      if (c == prev_cls) begin
        if (run_len != STREAK_MAX) run_len = run_len + 1'b1;
      end else begin
        prev_cls = c;
        run_len  = '0;
      end
      if (c == CLS_SERIAL) begin
        if (run_len >= SERIAL_REPEATS) begin
          passive = 1'b0;
          uart    = 1'b1;
        end
      end else if (run_len >= thr.confirm) begin
        case (c)
          CLS_TRAIN:  dev_held = DEV_TRAIN;
          CLS_SIMPLE: dev_held = DEV_SIMPLE;
          default:    dev_held = DEV_LIGHT;
        endcase
        passive = 1'b1;
      end
    end

    clear_extremes();
    res = '{c, run_len, dev_held, passive, uart};
    return 1'b1;
  endfunction

  // ------------------------------------------------------------ checking

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Result channel monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result transaction with nothing outstanding");
      end else begin
        head_want = expected_q.pop_front();
        if (out_window_class !== head_want.window_class ||
            out_streak       !== head_want.streak       ||
            out_device_type  !== head_want.device_type  ||
            out_dumb_device  !== head_want.dumb_device  ||
            out_uart_request !== head_want.uart_request)
          report_mismatch($sformatf(
            "class %0d/%0d streak %0d/%0d type %0d/%0d dumb %0b/%0b uart %0b/%0b",
            out_window_class, head_want.window_class, out_streak, head_want.streak,
            out_device_type, head_want.device_type, out_dumb_device,
            head_want.dumb_device, out_uart_request, head_want.uart_request));
      end
    end
  end

  // Receiver: own stall pattern, plus a long hold-off on request
  initial begin : rx_pattern
    int mode;
    int mode_left;
    int hold_left;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 300;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(10, 150);
        end
        mode_left--;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // ------------------------------------------------------------ stimulus

  function automatic logic [MV_W-1:0] level_sample(input int lo, input int hi, input int k);
    int v;
    if (k == 0) v = lo;
    else if (k == 1) v = hi;
    else v = $urandom_range(lo, hi);
    // full scale may also arrive as an over-range reading
    if (v == MV_TOP && $urandom_range(0, 2) == 0) v = $urandom_range(MV_TOP + 1, RAW_TOP);
    return MV_W'(v);
  endfunction

  function automatic void push_window(input int c0_lo, input int c0_hi, input int c1_lo,
                                      input int c1_hi, input int len, input bit typed,
                                      input result_t want);
    stim_t s;
    for (int k = 0; k < len; k++) begin
      s.ch0   = level_sample(c0_lo, c0_hi, k);
      s.ch1   = level_sample(c1_lo, c1_hi, k);
      s.typed = typed && (k == len - 1);
      s.want  = want;
      stim_q.push_back(s);
    end
  endfunction

  // Span kept under the flat threshold (zero if that is zero) and inside full scale
  function automatic int steady_span(input int lo);
    int cap;
    cap = (thr.flat_swing > 0) ? int'(thr.flat_swing) - 1 : 0;
    if (cap > MV_TOP - lo) cap = MV_TOP - lo;
    return $urandom_range(0, cap);
  endfunction

  // One window aimed at a class under the current thresholds
  function automatic void gen_window(input int kind, input int len);
    int c0_lo, c0_hi, c1_lo, c1_hi, span;
    c0_lo = $urandom_range(0, MV_TOP);
    c0_hi = $urandom_range(c0_lo, MV_TOP);
    c1_lo = $urandom_range(0, MV_TOP);
    c1_hi = $urandom_range(c1_lo, MV_TOP);
    case (kind)
      KIND_SERIAL: begin
        span  = $urandom_range(thr.uart_swing, MV_TOP);
        c1_lo = $urandom_range(0, MV_TOP - span);
        c1_hi = c1_lo + span;
      end
      KIND_TRAIN, KIND_SIMPLE, KIND_LIGHT: begin
        if (kind == KIND_TRAIN) c0_lo = $urandom_range(thr.high_level, MV_TOP);
        else c0_lo = $urandom_range(0, thr.low_level);
        c0_hi = c0_lo + steady_span(c0_lo);
        if (kind == KIND_LIGHT) c1_lo = $urandom_range(thr.ch1_high, MV_TOP);
        else c1_lo = $urandom_range(0, thr.ch1_low);
        c1_hi = c1_lo + steady_span(c1_lo);
      end
      KIND_NOISE: begin
        c0_lo = 0;
        c0_hi = RAW_TOP;
        c1_lo = RAW_TOP;
        c1_hi = 0;
      end
      default: ;
    endcase
    push_window(c0_lo, c0_hi, c1_lo, c1_hi, len, 1'b0, NO_WANT);
  endfunction

  // Mostly whole windows in class runs, sometimes a broken tail
  function automatic void fill_phase(input int nwin, input int only_kind);
    int made, kind, reps;
    made = 0;
    if (win_count != 0) gen_window(only_kind < 0 ? KIND_LEVEL : only_kind,
                                   WIN_LEN - int'(win_count));
    while (made < nwin) begin
      kind = (only_kind < 0) ? $urandom_range(KIND_SERIAL, KIND_NOISE) : only_kind;
      reps = (only_kind < 0) ? $urandom_range(1, 7) : 1;
      repeat (reps) gen_window(kind, WIN_LEN);
      made += reps;
    end
    if (only_kind < 0 && $urandom_range(0, 2) == 0)
      gen_window(KIND_NOISE, $urandom_range(1, WIN_LEN - 1));
  endfunction

  // Offer one sample pair and wait for its transaction
  task automatic put_pair(input stim_t s);
    result_t got;
    in_valid  <= 1'b1;
    in_ch0_mv <= s.ch0;
    in_ch1_mv <= s.ch1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (advance_window(s.ch0, s.ch1, got)) expected_q.push_back(s.typed ? s.want : got);
  endtask

  // Drain the stimulus queue, in bursts when gappy; valid stays high at the end
  task automatic drive_stim(input bit gappy);
    int burst;
    burst = $urandom_range(1, 40);
    while (stim_q.size() != 0) begin
      put_pair(stim_q.pop_front());
      if (gappy && stim_q.size() != 0) begin
        burst--;
        if (burst == 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
          burst = $urandom_range(1, 40);
        end
      end
    end
  endtask

  // Stop offering, wait for every outstanding result, then let the pipeline idle
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write; cfg_valid is left high for back-to-back writes
  task automatic write_reg(input logic [2:0] idx, input logic [MV_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_UART_SWING: thr.uart_swing = data;
      REG_HIGH_LEVEL: thr.high_level = data;
      REG_LOW_LEVEL:  thr.low_level  = data;
      REG_FLAT_SWING: thr.flat_swing = data;
      REG_CH1_LOW:    thr.ch1_low    = data;
      REG_CH1_HIGH:   thr.ch1_high   = data;
      REG_CONFIRM:    thr.confirm    = data[CNT_W-1:0];
      default: ;
    endcase
  endtask

  function automatic cfg_t draw_thresholds(input int style);
    cfg_t t;
    case (style)
      TH_ZERO: t = '0;
      TH_TOP:  t = '{FULL_MV, FULL_MV, FULL_MV, FULL_MV, FULL_MV, FULL_MV, STREAK_MAX};
      TH_OVERLAP: t = '{13'd4000, 13'd1500, 13'd3500, 13'd1000, 13'd2000, 13'd1000, 8'd1};
      TH_SAT: t = '{RST_UART_SWING, RST_HIGH_LEVEL, RST_LOW_LEVEL, RST_FLAT_SWING,
                    RST_CH1_LOW, RST_CH1_HIGH, STREAK_MAX};
      TH_WIDE: begin
        t.uart_swing = $urandom_range(0, MV_TOP);
        t.high_level = $urandom_range(0, MV_TOP);
        t.low_level  = $urandom_range(0, MV_TOP);
        t.flat_swing = $urandom_range(0, MV_TOP);
        t.ch1_low    = $urandom_range(0, MV_TOP);
        t.ch1_high   = $urandom_range(0, MV_TOP);
        t.confirm    = $urandom_range(0, 255);
      end
      default: begin
        t.uart_swing = $urandom_range(1500, MV_TOP);
        t.high_level = $urandom_range(2000, 4800);
        t.low_level  = $urandom_range(200, 2000);
        t.flat_swing = $urandom_range(50, 1500);
        t.ch1_low    = $urandom_range(0, 1500);
        t.ch1_high   = $urandom_range(1500, 4800);
        t.confirm    = $urandom_range(0, 6);
      end
    endcase
    return t;
  endfunction

  // Write the whole set; confirm may carry stray upper bits, which are dropped
  task automatic load_thresholds(input cfg_t t, input bit poke_spare);
    write_reg(REG_UART_SWING, t.uart_swing);
    write_reg(REG_HIGH_LEVEL, t.high_level);
    write_reg(REG_LOW_LEVEL,  t.low_level);
    write_reg(REG_FLAT_SWING, t.flat_swing);
    write_reg(REG_CH1_LOW,    t.ch1_low);
    write_reg(REG_CH1_HIGH,   t.ch1_high);
    write_reg(REG_CONFIRM,    {5'($urandom_range(0, 31)), t.confirm});
    if (poke_spare) write_reg(REG_SPARE, MV_W'($urandom_range(0, RAW_TOP)));
    cfg_valid <= 1'b0;
  endtask

  // Main sequence
  initial begin : main_seq
    int guard;
    reset_classifier();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed windows
    for (int r = 0; r < 15; r++) begin
      if (dir_rows[r].confirm_set >= 0) begin
        drive_stim(1'b1);
        settle();
        write_reg(REG_CONFIRM, MV_W'(dir_rows[r].confirm_set));
        cfg_valid <= 1'b0;
      end
      push_window(dir_rows[r].c0_lo, dir_rows[r].c0_hi, dir_rows[r].c1_lo,
                  dir_rows[r].c1_hi, WIN_LEN, dir_rows[r].typed, dir_rows[r].want);
    end
    drive_stim(1'b1);

    // Random phases, one threshold set each
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      load_thresholds(draw_thresholds(phase_style[ph]), phase_style[ph] == TH_TOP);
      fill_phase($urandom_range(4, 6), KIND_ANY);
      if (ph == PRESSURE_PHASE) begin
        // receiver holds off while items keep coming, so the input backs up
        hold_req = 1'b1;
        drive_stim(1'b0);
      end else begin
        drive_stim($urandom_range(0, 3) != 0);
      end
    end

    // Wind down
    in_valid <= 1'b0;
    guard = 0;
    while (expected_q.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (expected_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/apdc_pkg.sv
rtl/apdc_judge.sv
rtl/analog_port_device_classifier_top.sv
sim/tb_analog_port_device_classifier_top.sv
